// File: src/pbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_pkg
// Shared types and constants of the page buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

  localparam int FRAMES    = 16;
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int NACT_W    = FRAME_W + 1;
  localparam int PAGE_BITS = 24;
  localparam int PIN_BITS  = 8;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int MCNT_W    = $clog2(CNT_W);
  localparam int FIU_W     = 5;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;

  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FIU    = 1'b1;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PIN     = 3'd0,
    OP_UNPIN   = 3'd1,
    OP_DIRTY   = 3'd2,
    OP_FORCE   = 3'd3,
    OP_FLUSH   = 3'd4,
    OP_INSPECT = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_EXEC,
    S_FLUSH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic mod;
    logic exec;
    logic flush;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_mod;
    logic mod_last;
    logic flush_done;
    logic res_last;
  } sts_t;

endpackage

// File: src/pbpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_ctrl
// Sequencer: frame scan, fifo start computation, update, flush walk and
// result handshake.
// ----------------------------------------------------------------------------
module pbpm_ctrl
  import pbpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] operation_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cmd_t            cmd_o,
  input  sts_t            sts_i
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (operation_i)
            OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE: state_d = S_SCAN;
            OP_FLUSH:                             state_d = S_FLUSH;
            default:                              state_d = S_EXEC;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_EXEC;
      end
      S_MOD: begin
        if (sts_i.mod_last) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = sts_i.need_mod ? S_MOD : S_OUT;
      end
      S_FLUSH: begin
        if (sts_i.flush_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = sts_i.res_last ? S_IDLE : S_FLUSH;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      S_SCAN:  cmd_o.scan = 1'b1;
      S_MOD:   cmd_o.mod = 1'b1;
      S_EXEC:  cmd_o.exec = !sts_i.need_mod;
      S_FLUSH: cmd_o.flush = 1'b1;
      S_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

// File: src/pbpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpm_datapath
// Frame table, counters, scan trackers, fifo start remainder unit and the
// result register.
// ----------------------------------------------------------------------------
module pbpm_datapath
  import pbpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [FIU_W-1:0]     cfg_data_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic [FRAME_W-1:0]   frame_index_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [ST_W-1:0]      status_o,
  output logic [FRAME_W-1:0]   frame_o,
  output logic                 load_request_o,
  output logic                 writeback_valid_o,
  output logic [PAGE_BITS-1:0] writeback_page_o,
  output logic                 entry_valid_o,
  output logic [PAGE_BITS-1:0] entry_page_o,
  output logic                 entry_dirty_o,
  output logic [PIN_BITS-1:0]  entry_pins_o,
  output logic [CNT_W-1:0]     reads_total_o,
  output logic [CNT_W-1:0]     writes_total_o,
  output logic                 last_o
);

  // configuration
  logic             policy_q;
  logic [FIU_W-1:0] fiu_q;
  logic [NACT_W-1:0] nact;

  // current item
  logic [OP_W-1:0]      op_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [FRAME_W-1:0]   fi_q;

  // frame table
  logic [PAGE_BITS-1:0] tag_q   [FRAMES];
  logic                 valid_q [FRAMES];
  logic                 dirty_q [FRAMES];
  logic [PIN_BITS-1:0]  pins_q  [FRAMES];
  logic [STAMP_W-1:0]   stamp_q [FRAMES];
  logic [STAMP_W-1:0]   stamp_cnt_q;
  logic [CNT_W-1:0]     load_cnt_q, write_cnt_q;
  logic [CNT_W-1:0]     load_d, write_d;

  // scan trackers
  logic [NACT_W-1:0]  idx_q;
  logic               hit_q, emp_q, lru_q;
  logic [FRAME_W-1:0] hit_idx_q, emp_idx_q, lru_idx_q;
  logic [STAMP_W-1:0] lru_stamp_q;

  // remainder unit for the fifo start
  logic [FRAME_W-1:0] rem_q;
  logic [MCNT_W-1:0]  mcnt_q;
  logic               mod_done_q;
  logic [NACT_W-1:0]  trial;

  // single read port
  logic [FRAME_W-1:0]   rd_addr;
  logic [PAGE_BITS-1:0] rd_tag;
  logic                 rd_valid, rd_dirty;
  logic [PIN_BITS-1:0]  rd_pins;

  // victim selection
  logic               vic_ok;
  logic [FRAME_W-1:0] vic_idx;
  logic               fifo_ok;
  logic [FRAME_W-1:0] fifo_idx;

  // flush walk
  logic flush_end, flush_hit, more;

  // update controls
  logic                r_last, r_load, r_wb, r_ev, r_ed;
  logic [ST_W-1:0]     r_status;
  logic [FRAME_W-1:0]  r_frame;
  logic [PAGE_BITS-1:0] r_wbp, r_ep;
  logic [PIN_BITS-1:0] r_epins;
  logic [FRAME_W-1:0]  w_addr;
  logic                w_tag, w_dirty_we, w_dirty_val, w_pins_we, w_touch, w_load, w_write;
  logic [PIN_BITS-1:0] w_pins_val;
  logic                res_we;

  // active frame count, clamped
  always_comb begin
    if (fiu_q == '0) begin
      nact = NACT_W'(1);
    end else if (fiu_q > FIU_W'(FRAMES)) begin
      nact = NACT_W'(FRAMES);
    end else begin
      nact = NACT_W'(fiu_q);
    end
  end

  // read address
  always_comb begin
    rd_addr = idx_q[FRAME_W-1:0];
    if (cmd_i.exec) begin
      case (op_q)
        OP_PIN:                         rd_addr = hit_q ? hit_idx_q : vic_idx;
        OP_UNPIN, OP_DIRTY, OP_FORCE:   rd_addr = hit_idx_q;
        OP_INSPECT:                     rd_addr = fi_q;
        default:                        rd_addr = idx_q[FRAME_W-1:0];
      endcase
    end
  end

  assign rd_tag   = tag_q[rd_addr];
  assign rd_valid = valid_q[rd_addr];
  assign rd_dirty = dirty_q[rd_addr];
  assign rd_pins  = pins_q[rd_addr];

  // fifo victim: first unpinned frame at or after the start, else first overall
  always_comb begin
    fifo_ok  = 1'b0;
    fifo_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (pins_q[i] == '0 && NACT_W'(i) < nact) begin
        fifo_ok  = 1'b1;
        fifo_idx = FRAME_W'(i);
      end
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (pins_q[i] == '0 && NACT_W'(i) < nact && FRAME_W'(i) >= rem_q) begin
        fifo_idx = FRAME_W'(i);
      end
    end
  end

  // victim choice
  always_comb begin
    if (emp_q) begin
      vic_ok  = 1'b1;
      vic_idx = emp_idx_q;
    end else if (policy_q == POL_LRU) begin
      vic_ok  = lru_q;
      vic_idx = lru_idx_q;
    end else begin
      vic_ok  = fifo_ok;
      vic_idx = fifo_idx;
    end
  end

  // flush walk status
  assign flush_end = idx_q >= nact;
  assign flush_hit = !flush_end && valid_q[idx_q[FRAME_W-1:0]] &&
                     dirty_q[idx_q[FRAME_W-1:0]] && pins_q[idx_q[FRAME_W-1:0]] == '0;

  // another flush candidate after the current frame
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (valid_q[i] && dirty_q[i] && pins_q[i] == '0 &&
          NACT_W'(i) < nact && NACT_W'(i) > idx_q) begin
        more = 1'b1;
      end
    end
  end

  // remainder step
  assign trial = {rem_q, load_cnt_q[MCNT_W'(CNT_W - 1) - mcnt_q]};

  // status to the sequencer
  always_comb begin
    sts_o.scan_last  = idx_q == nact - NACT_W'(1);
    sts_o.need_mod   = op_q == OP_PIN && !hit_q && !emp_q && policy_q == POL_FIFO &&
                       !mod_done_q;
    sts_o.mod_last   = mcnt_q == MCNT_W'(CNT_W - 1);
    sts_o.flush_done = flush_end || flush_hit;
    sts_o.res_last   = last_o;
  end

  // operation effects and result fields
  always_comb begin
    r_status    = ST_OK;
    r_frame     = '0;
    r_load      = 1'b0;
    r_wb        = 1'b0;
    r_wbp       = '0;
    r_ev        = 1'b0;
    r_ep        = '0;
    r_ed        = 1'b0;
    r_epins     = '0;
    r_last      = 1'b1;
    w_addr      = rd_addr;
    w_tag       = 1'b0;
    w_dirty_we  = 1'b0;
    w_dirty_val = 1'b0;
    w_pins_we   = 1'b0;
    w_pins_val  = '0;
    w_touch     = 1'b0;
    w_load      = 1'b0;
    w_write     = 1'b0;
    if (cmd_i.exec) begin
      case (op_q)
        OP_PIN: begin
          if (hit_q) begin
            r_frame    = hit_idx_q;
            w_pins_we  = 1'b1;
            w_pins_val = (rd_pins == PIN_MAX) ? rd_pins : rd_pins + PIN_BITS'(1);
            w_touch    = 1'b1;
          end else if (!vic_ok) begin
            r_status = ST_FULL;
          end else begin
            r_frame    = vic_idx;
            r_load     = 1'b1;
            r_wb       = !emp_q && rd_dirty;
            r_wbp      = r_wb ? rd_tag : '0;
            w_write    = r_wb;
            w_tag      = 1'b1;
            w_dirty_we = 1'b1;
            w_pins_we  = 1'b1;
            w_pins_val = PIN_BITS'(1);
            w_load     = 1'b1;
            w_touch    = 1'b1;
          end
        end
        OP_UNPIN, OP_DIRTY, OP_FORCE: begin
          if (!hit_q) begin
            r_status = ST_MISS;
          end else begin
            r_frame = hit_idx_q;
            if (op_q == OP_UNPIN) begin
              w_pins_we  = 1'b1;
              w_pins_val = (rd_pins == '0) ? rd_pins : rd_pins - PIN_BITS'(1);
            end else if (op_q == OP_DIRTY) begin
              w_dirty_we  = 1'b1;
              w_dirty_val = 1'b1;
            end else begin
              w_dirty_we = 1'b1;
              w_write    = 1'b1;
              r_wb       = 1'b1;
              r_wbp      = rd_tag;
            end
          end
        end
        OP_INSPECT: begin
          r_frame = fi_q;
          r_ev    = rd_valid;
          r_ep    = rd_valid ? rd_tag : '0;
          r_ed    = rd_valid && rd_dirty;
          r_epins = rd_pins;
        end
        default: ;
      endcase
    end else if (cmd_i.flush && flush_hit) begin
      r_frame    = idx_q[FRAME_W-1:0];
      r_wb       = 1'b1;
      r_wbp      = rd_tag;
      w_dirty_we = 1'b1;
      w_write    = 1'b1;
      r_last     = !more;
    end
  end

  assign load_d  = load_cnt_q + CNT_W'(w_load);
  assign write_d = write_cnt_q + CNT_W'(w_write);
  assign res_we  = cmd_i.exec || (cmd_i.flush && (flush_hit || flush_end));

  // control state, flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_FIFO;
      fiu_q       <= FIU_W'(FRAMES);
      stamp_cnt_q <= '0;
      load_cnt_q  <= '0;
      write_cnt_q <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      emp_q       <= 1'b0;
      lru_q       <= 1'b0;
      mcnt_q      <= '0;
      rem_q       <= '0;
      mod_done_q  <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        pins_q[i]  <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POLICY: policy_q <= cfg_data_i[0];
          CFG_FIU:    fiu_q    <= cfg_data_i;
          default:    ;
        endcase
      end
      // new item: restart trackers
      if (cmd_i.accept) begin
        idx_q      <= '0;
        hit_q      <= 1'b0;
        emp_q      <= 1'b0;
        lru_q      <= 1'b0;
        mcnt_q     <= '0;
        rem_q      <= '0;
        mod_done_q <= 1'b0;
      end
      // one frame per cycle scan
      if (cmd_i.scan) begin
        if (valid_q[idx_q[FRAME_W-1:0]] && tag_q[idx_q[FRAME_W-1:0]] == page_q && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[idx_q[FRAME_W-1:0]] && !emp_q) begin
          emp_q <= 1'b1;
        end
        if (pins_q[idx_q[FRAME_W-1:0]] == '0 &&
            (!lru_q || stamp_q[idx_q[FRAME_W-1:0]] < lru_stamp_q)) begin
          lru_q <= 1'b1;
        end
        idx_q <= idx_q + NACT_W'(1);
      end
      // one dividend bit per cycle
      if (cmd_i.mod) begin
        rem_q  <= (trial >= nact) ? FRAME_W'(trial - nact) : FRAME_W'(trial);
        mcnt_q <= mcnt_q + MCNT_W'(1);
        if (sts_o.mod_last) mod_done_q <= 1'b1;
      end
      // flush walk advances
      if (cmd_i.flush && !flush_end) begin
        idx_q <= idx_q + NACT_W'(1);
      end
      // frame updates
      if (w_tag) valid_q[w_addr] <= 1'b1;
      if (w_dirty_we) dirty_q[w_addr] <= w_dirty_val;
      if (w_pins_we) pins_q[w_addr] <= w_pins_val;
      if (w_touch) begin
        stamp_cnt_q <= stamp_cnt_q + STAMP_W'(1);
        if (policy_q == POL_LRU) stamp_q[w_addr] <= stamp_cnt_q + STAMP_W'(1);
      end
      load_cnt_q  <= load_d;
      write_cnt_q <= write_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      page_q <= page_number_i;
      fi_q   <= frame_index_i;
    end
    if (cmd_i.scan) begin
      if (valid_q[idx_q[FRAME_W-1:0]] && tag_q[idx_q[FRAME_W-1:0]] == page_q && !hit_q) begin
        hit_idx_q <= idx_q[FRAME_W-1:0];
      end
      if (!valid_q[idx_q[FRAME_W-1:0]] && !emp_q) begin
        emp_idx_q <= idx_q[FRAME_W-1:0];
      end
      if (pins_q[idx_q[FRAME_W-1:0]] == '0 &&
          (!lru_q || stamp_q[idx_q[FRAME_W-1:0]] < lru_stamp_q)) begin
        lru_idx_q   <= idx_q[FRAME_W-1:0];
        lru_stamp_q <= stamp_q[idx_q[FRAME_W-1:0]];
      end
    end
    if (w_tag) tag_q[w_addr] <= page_q;
    if (res_we) begin
      status_o          <= r_status;
      frame_o           <= r_frame;
      load_request_o    <= r_load;
      writeback_valid_o <= r_wb;
      writeback_page_o  <= r_wbp;
      entry_valid_o     <= r_ev;
      entry_page_o      <= r_ep;
      entry_dirty_o     <= r_ed;
      entry_pins_o      <= r_epins;
      reads_total_o     <= load_d;
      writes_total_o    <= write_d;
      last_o            <= r_last;
    end
  end

endmodule

// File: src/page_buffer_pool_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_pool_manager_unit
// Frame bookkeeping for a page buffer pool with fifo or lru replacement.
// ----------------------------------------------------------------------------
// Operations are handled one at a time. Pin, unpin, mark dirty and force scan
// the active frames one per cycle, then pass through the update state; a fifo
// pin that has to evict first runs a bit-serial remainder unit that forms the
// fifo start from the load count, and then passes through the update state
// once more. Flush walks the active frames one per cycle, pausing while a beat
// waits to be taken, and hands out one beat per dirty unpinned frame, or a
// single beat if there is none; inspect and unknown codes go straight to the
// update state. Each result beat is held in an output register until taken,
// and a new operation is accepted once the final beat (last set) has left.
module page_buffer_pool_manager_unit
  import pbpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [FIU_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic [FRAME_W-1:0]   frame_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ST_W-1:0]      status_o,
  output logic [FRAME_W-1:0]   frame_o,
  output logic                 load_request_o,
  output logic                 writeback_valid_o,
  output logic [PAGE_BITS-1:0] writeback_page_o,
  output logic                 entry_valid_o,
  output logic [PAGE_BITS-1:0] entry_page_o,
  output logic                 entry_dirty_o,
  output logic [PIN_BITS-1:0]  entry_pins_o,
  output logic [CNT_W-1:0]     reads_total_o,
  output logic [CNT_W-1:0]     writes_total_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pbpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // frame table and result register
  pbpm_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .page_number_i     (page_number_i),
    .frame_index_i     (frame_index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .frame_o           (frame_o),
    .load_request_o    (load_request_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_page_o  (writeback_page_o),
    .entry_valid_o     (entry_valid_o),
    .entry_page_o      (entry_page_o),
    .entry_dirty_o     (entry_dirty_o),
    .entry_pins_o      (entry_pins_o),
    .reads_total_o     (reads_total_o),
    .writes_total_o    (writes_total_o),
    .last_o            (last_o)
  );

endmodule
